[rtl/core/mstl_pkg.sv]
// Shared constants and types for the media sample table lookup unit.
// Used by mstl_arith, mstl_tables and media_sample_table_lookup_unit.
`default_nettype none
package mstl_pkg;

  localparam int TIME_RUNS    = 1024;
  localparam int CHUNK_GROUPS = 256;
  localparam int MAX_CHUNKS   = 4096;
  localparam int MAX_SAMPLES  = 4096;

  localparam int RUN_AW = $clog2(TIME_RUNS);
  localparam int GRP_AW = $clog2(CHUNK_GROUPS);
  localparam int CHK_AW = $clog2(MAX_CHUNKS);
  localparam int SMP_AW = $clog2(MAX_SAMPLES);

  localparam int WORD_W  = 32;
  localparam int TIME_W  = 31;
  localparam int ENTRY_W = 12;
  localparam int OP_W    = 3;
  localparam int CFG_IW  = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD_RUN   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_GROUP = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_OFF   = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD_SIZE  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_CHUNK_MODE   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_UNIFORM_SIZE = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_RUN_COUNT    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_GROUP_COUNT  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_TOTAL        = 3'd4;

  typedef enum logic {ARITH_MUL, ARITH_DIV} arith_op_t;

  typedef struct packed {
    logic              start;
    arith_op_t         op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic                done;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0]   quot;
    logic [WORD_W-1:0]   rem;
  } arith_rsp_t;

  typedef struct packed {
    logic               run_we;
    logic               grp_we;
    logic               off_we;
    logic               size_we;
    logic [ENTRY_W-1:0] index;
    logic [WORD_W-1:0]  a;
    logic [WORD_W-1:0]  b;
    logic [WORD_W-1:0]  c;
  } tbl_wr_t;

  typedef struct packed {
    logic [2*WORD_W-1:0] run;
    logic [2*WORD_W-1:0] grp;
    logic [WORD_W-1:0]   desc;
    logic [WORD_W-1:0]   off;
    logic [WORD_W-1:0]   size;
  } tbl_rd_t;

endpackage
`default_nettype wire

[rtl/core/media_sample_table_lookup_unit.sv]
// Top level of the media sample table lookup unit: sequencer, config regs.
// Depends on mstl_pkg, mstl_arith and mstl_tables.
//
// Load beats (opcodes 0 to 3) write one table entry and give no result; an
// index beyond a table's depth is dropped, as are opcodes 5 to 7. A query
// beat starts a walk that holds in_stall high until its result beat is
// registered on the output. A query's cost grows with the time runs and
// chunk groups passed; it includes two divides on the shared restoring
// divider (one bit a cycle) and, in sample mode, the sizes summed inside
// the chunk through the one read port of the size store, or in chunk mode
// two multiplies. The walks are paced by the single read port of each
// store and by the one shared multiply/divide unit. A finished result waits
// in the output register while the next beat is taken. Samples past
// total_samples, zero durations, zero samples per chunk and chunk numbers of
// zero or beyond the offset store give found = 0 with all other fields zero.
// The stores have no reset; query only entries already loaded.
`default_nettype none
module media_sample_table_lookup_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [mstl_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [mstl_pkg::WORD_W-1:0]   cfg_data,
  // input beats
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [mstl_pkg::OP_W-1:0]     opcode,
  input  wire logic [mstl_pkg::ENTRY_W-1:0]  entry_index,
  input  wire logic [mstl_pkg::WORD_W-1:0]   word_a,
  input  wire logic [mstl_pkg::WORD_W-1:0]   word_b,
  input  wire logic [mstl_pkg::WORD_W-1:0]   word_c,
  input  wire logic [mstl_pkg::TIME_W-1:0]   query_time,
  // result beats
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          found,
  output      logic [mstl_pkg::WORD_W-1:0]   sample_time,
  output      logic [mstl_pkg::WORD_W-1:0]   sample_duration,
  output      logic [mstl_pkg::WORD_W-1:0]   samples_in_result,
  output      logic [mstl_pkg::WORD_W-1:0]   byte_offset,
  output      logic [mstl_pkg::WORD_W-1:0]   byte_size,
  output      logic [mstl_pkg::WORD_W-1:0]   description_id
);

  localparam int RUN_AW = mstl_pkg::RUN_AW;
  localparam int GRP_AW = mstl_pkg::GRP_AW;
  localparam int CHK_AW = mstl_pkg::CHK_AW;
  localparam int SMP_AW = mstl_pkg::SMP_AW;
  localparam int TW     = mstl_pkg::TIME_W;
  localparam int WW     = mstl_pkg::WORD_W;
  localparam int CS_W   = 43;  // sum of up to TIME_RUNS-1 32-bit run counts

  typedef enum logic [4:0] {
    S_IDLE, S_RUN_RD, S_RUN_CHK, S_RUN_MUL, S_DIV1, S_DIV1_WAIT,
    S_GRP_RD0, S_GRP_RD1, S_GRP_CHK, S_GRP_MUL, S_GRP_FIN, S_DIV2_WAIT,
    S_OFF_RD, S_OFF_GET, S_CM_MUL1, S_CM_MUL2, S_SZ_RD, S_SZ_ACC, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic        chunk_mode;
  logic [31:0] uniform_sample_size;
  logic [10:0] time_run_count;
  logic [8:0]  chunk_group_count;
  logic [12:0] total_samples;

  // working registers
  logic [TW-1:0]     t;
  logic [TW-1:0]     cur_time;
  logic [CS_W-1:0]   cur_sample;
  logic [RUN_AW-1:0] run_i;
  logic [2*WW-1:0]   run_word;
  logic [TW-1:0]     aligned;
  logic [SMP_AW-1:0] sample;
  logic [GRP_AW-1:0] g;
  logic [SMP_AW-1:0] gs;
  logic [2*WW-1:0]   grp_word;
  logic [WW-1:0]     desc;
  logic [CHK_AW-1:0] chunk_idx;
  logic [SMP_AW-1:0] j;
  logic [WW-1:0]     off;
  logic [WW-1:0]     res_dur;
  logic [WW-1:0]     res_size;
  logic              nf;

  mstl_pkg::arith_req_t req;
  mstl_pkg::arith_rsp_t rsp;
  mstl_pkg::tbl_wr_t    wr;
  mstl_pkg::tbl_rd_t    rd;

  logic accept;
  logic [RUN_AW:0]   runs_eff;
  logic [GRP_AW:0]   groups_eff;
  logic [SMP_AW:0]   total_eff;
  logic [64:0]       run_end;
  logic [43:0]       sample_sum;
  logic [64:0]       grp_end;
  logic [WW:0]       chunk;
  logic [WW:0]       chunk_m1;
  logic [GRP_AW-1:0] g_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // run and group counts clamped to 1..depth, total samples to depth
  always_comb begin
    if (time_run_count == '0) runs_eff = (RUN_AW+1)'(1);
    else if (32'(time_run_count) > 32'(mstl_pkg::TIME_RUNS))
      runs_eff = (RUN_AW+1)'(mstl_pkg::TIME_RUNS);
    else runs_eff = (RUN_AW+1)'(time_run_count);
    if (chunk_group_count == '0) groups_eff = (GRP_AW+1)'(1);
    else if (32'(chunk_group_count) > 32'(mstl_pkg::CHUNK_GROUPS))
      groups_eff = (GRP_AW+1)'(mstl_pkg::CHUNK_GROUPS);
    else groups_eff = (GRP_AW+1)'(chunk_group_count);
    if (32'(total_samples) > 32'(mstl_pkg::MAX_SAMPLES))
      total_eff = (SMP_AW+1)'(mstl_pkg::MAX_SAMPLES);
    else total_eff = (SMP_AW+1)'(total_samples);
  end

  always_comb begin
    run_end    = 65'(cur_time) + 65'(rsp.prod);
    sample_sum = 44'(cur_sample) + 44'(rsp.quot);
    grp_end    = 65'(gs) + 65'(rsp.prod);
    chunk      = {1'b0, rsp.quot} + {1'b0, grp_word[2*WW-1:WW]};
    chunk_m1   = chunk - 33'd1;
    g_next     = g + GRP_AW'(1);
  end

  // table writes straight from accepted load beats
  always_comb begin
    wr.index   = entry_index;
    wr.a       = word_a;
    wr.b       = word_b;
    wr.c       = word_c;
    wr.run_we  = accept && opcode == mstl_pkg::OP_LOAD_RUN
                 && 32'(entry_index) < 32'(mstl_pkg::TIME_RUNS);
    wr.grp_we  = accept && opcode == mstl_pkg::OP_LOAD_GROUP
                 && 32'(entry_index) < 32'(mstl_pkg::CHUNK_GROUPS);
    wr.off_we  = accept && opcode == mstl_pkg::OP_LOAD_OFF
                 && 32'(entry_index) < 32'(mstl_pkg::MAX_CHUNKS);
    wr.size_we = accept && opcode == mstl_pkg::OP_LOAD_SIZE
                 && 32'(entry_index) < 32'(mstl_pkg::MAX_SAMPLES);
  end

  mstl_tables u_tables (
    .clk       (clk),
    .wr        (wr),
    .run_addr  (run_i),
    .grp_addr  ((state == S_GRP_RD1) ? g_next : g),
    .off_addr  (chunk_idx),
    .size_addr (j),
    .rd        (rd)
  );

  mstl_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_mode          <= 1'b0;
      uniform_sample_size <= '0;
      time_run_count      <= 11'd1;
      chunk_group_count   <= 9'd1;
      total_samples       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        mstl_pkg::CFG_CHUNK_MODE:   chunk_mode          <= cfg_data[0];
        mstl_pkg::CFG_UNIFORM_SIZE: uniform_sample_size <= cfg_data;
        mstl_pkg::CFG_RUN_COUNT:    time_run_count      <= cfg_data[10:0];
        mstl_pkg::CFG_GROUP_COUNT:  chunk_group_count   <= cfg_data[8:0];
        mstl_pkg::CFG_TOTAL:        total_samples       <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      req.start <= 1'b0;
      // S_DONE reloads the output register itself when the beat leaves
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && opcode == mstl_pkg::OP_QUERY) begin
            t          <= query_time;
            cur_time   <= '0;
            cur_sample <= '0;
            run_i      <= '0;
            nf         <= 1'b0;
            state      <= S_RUN_RD;
          end
        end
        S_RUN_RD: state <= S_RUN_CHK;
        S_RUN_CHK: begin
          run_word <= rd.run;
          // last run in use catches every later time
          if ((RUN_AW+1)'(run_i) + (RUN_AW+1)'(1) >= runs_eff) begin
            state <= S_DIV1;
          end else begin
            req.start <= 1'b1;
            req.op    <= mstl_pkg::ARITH_MUL;
            req.a     <= rd.run[2*WW-1:WW];
            req.b     <= rd.run[WW-1:0];
            state     <= S_RUN_MUL;
          end
        end
        S_RUN_MUL: begin
          if (rsp.done) begin
            if (65'(t) < run_end) begin
              state <= S_DIV1;
            end else begin
              cur_time   <= cur_time + rsp.prod[TW-1:0];
              cur_sample <= cur_sample + CS_W'(run_word[2*WW-1:WW]);
              run_i      <= run_i + RUN_AW'(1);
              state      <= S_RUN_RD;
            end
          end
        end
        S_DIV1: begin
          if (run_word[WW-1:0] == '0) begin
            nf    <= 1'b1;
            state <= S_DONE;
          end else begin
            req.start <= 1'b1;
            req.op    <= mstl_pkg::ARITH_DIV;
            req.a     <= {1'b0, t - cur_time};
            req.b     <= run_word[WW-1:0];
            state     <= S_DIV1_WAIT;
          end
        end
        S_DIV1_WAIT: begin
          if (rsp.done) begin
            aligned <= t - rsp.rem[TW-1:0];
            if (sample_sum >= 44'(total_eff)) begin
              nf    <= 1'b1;
              state <= S_DONE;
            end else begin
              sample <= sample_sum[SMP_AW-1:0];
              g      <= '0;
              gs     <= '0;
              state  <= S_GRP_RD0;
            end
          end
        end
        S_GRP_RD0: state <= S_GRP_RD1;
        S_GRP_RD1: begin
          grp_word <= rd.grp;
          desc     <= rd.desc;
          // last group in use holds all remaining samples
          if ((GRP_AW+1)'(g) + (GRP_AW+1)'(1) == groups_eff) state <= S_GRP_FIN;
          else state <= S_GRP_CHK;
        end
        S_GRP_CHK: begin
          if (rd.grp[2*WW-1:WW] > grp_word[2*WW-1:WW]) begin
            req.start <= 1'b1;
            req.op    <= mstl_pkg::ARITH_MUL;
            req.a     <= rd.grp[2*WW-1:WW] - grp_word[2*WW-1:WW];
            req.b     <= grp_word[WW-1:0];
            state     <= S_GRP_MUL;
          end else begin
            // first chunk not ascending: empty group
            g     <= g_next;
            state <= S_GRP_RD0;
          end
        end
        S_GRP_MUL: begin
          if (rsp.done) begin
            if (65'(sample) < grp_end) begin
              state <= S_GRP_FIN;
            end else begin
              gs    <= gs + rsp.prod[SMP_AW-1:0];
              g     <= g_next;
              state <= S_GRP_RD0;
            end
          end
        end
        S_GRP_FIN: begin
          if (grp_word[WW-1:0] == '0) begin
            nf    <= 1'b1;
            state <= S_DONE;
          end else begin
            req.start <= 1'b1;
            req.op    <= mstl_pkg::ARITH_DIV;
            req.a     <= WW'(sample - gs);
            req.b     <= grp_word[WW-1:0];
            state     <= S_DIV2_WAIT;
          end
        end
        S_DIV2_WAIT: begin
          if (rsp.done) begin
            if (chunk == '0 || chunk > 33'(mstl_pkg::MAX_CHUNKS)) begin
              nf    <= 1'b1;
              state <= S_DONE;
            end else begin
              chunk_idx <= chunk_m1[CHK_AW-1:0];
              j         <= sample - rsp.rem[SMP_AW-1:0];
              state     <= S_OFF_RD;
            end
          end
        end
        S_OFF_RD: state <= S_OFF_GET;
        S_OFF_GET: begin
          off <= rd.off;
          if (chunk_mode) begin
            req.start <= 1'b1;
            req.op    <= mstl_pkg::ARITH_MUL;
            req.a     <= run_word[WW-1:0];
            req.b     <= grp_word[WW-1:0];
            state     <= S_CM_MUL1;
          end else begin
            res_dur <= run_word[WW-1:0];
            state   <= S_SZ_RD;
          end
        end
        S_CM_MUL1: begin
          if (rsp.done) begin
            res_dur   <= rsp.prod[WW-1:0];
            req.start <= 1'b1;
            req.op    <= mstl_pkg::ARITH_MUL;
            req.a     <= grp_word[WW-1:0];
            req.b     <= uniform_sample_size;
            state     <= S_CM_MUL2;
          end
        end
        S_CM_MUL2: begin
          if (rsp.done) begin
            res_size <= rsp.prod[WW-1:0];
            state    <= S_DONE;
          end
        end
        S_SZ_RD: state <= S_SZ_ACC;
        S_SZ_ACC: begin
          // sum sizes of earlier samples in the chunk; last read is our size
          if (j == sample) begin
            res_size <= rd.size;
            state    <= S_DONE;
          end else begin
            off   <= off + rd.size;
            j     <= j + SMP_AW'(1);
            state <= S_SZ_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            found             <= !nf;
            sample_time       <= nf ? '0 : WW'(aligned);
            sample_duration   <= nf ? '0 : res_dur;
            samples_in_result <= nf ? '0 : (chunk_mode ? grp_word[WW-1:0] : WW'(1));
            byte_offset       <= nf ? '0 : off;
            byte_size         <= nf ? '0 : res_size;
            description_id    <= nf ? '0 : desc;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/mstl_arith.sv]
// Shared arithmetic unit: registered 32x32 multiply, 32-step restoring divide.
// Depends on mstl_pkg.
`default_nettype none
module mstl_arith (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mstl_pkg::arith_req_t req,
  output      mstl_pkg::arith_rsp_t rsp
);

  logic [mstl_pkg::WORD_W-1:0]   divq;
  logic [mstl_pkg::WORD_W-1:0]   divr;
  logic [mstl_pkg::WORD_W-1:0]   divd;
  logic [4:0]                    cnt;
  logic                          busy;
  logic                          done;
  logic [2*mstl_pkg::WORD_W-1:0] prod;
  logic [mstl_pkg::WORD_W:0]     rem_sh;
  logic                          ge;

  always_comb begin
    rem_sh = {divr, divq[mstl_pkg::WORD_W-1]};
    ge     = rem_sh >= {1'b0, divd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.op == mstl_pkg::ARITH_MUL) begin
          prod <= 64'(req.a) * 64'(req.b);
          done <= 1'b1;
        end else begin
          divq <= req.a;
          divr <= '0;
          divd <= req.b;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        divr <= ge ? 32'(rem_sh - {1'b0, divd}) : rem_sh[mstl_pkg::WORD_W-1:0];
        divq <= {divq[mstl_pkg::WORD_W-2:0], ge};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = prod;
  assign rsp.quot = divq;
  assign rsp.rem  = divr;

endmodule
`default_nettype wire

[rtl/core/mstl_tables.sv]
// Sample table stores: time runs, chunk groups, chunk offsets, sample sizes.
// One write port shared by all, registered read per store. Depends on mstl_pkg.
`default_nettype none
module mstl_tables (
  input  wire logic                        clk,
  input  wire mstl_pkg::tbl_wr_t           wr,
  input  wire logic [mstl_pkg::RUN_AW-1:0] run_addr,
  input  wire logic [mstl_pkg::GRP_AW-1:0] grp_addr,
  input  wire logic [mstl_pkg::CHK_AW-1:0] off_addr,
  input  wire logic [mstl_pkg::SMP_AW-1:0] size_addr,
  output      mstl_pkg::tbl_rd_t           rd
);

  logic [2*mstl_pkg::WORD_W-1:0] run_mem  [mstl_pkg::TIME_RUNS];
  logic [2*mstl_pkg::WORD_W-1:0] grp_mem  [mstl_pkg::CHUNK_GROUPS];
  logic [mstl_pkg::WORD_W-1:0]   desc_mem [mstl_pkg::CHUNK_GROUPS];
  logic [mstl_pkg::WORD_W-1:0]   off_mem  [mstl_pkg::MAX_CHUNKS];
  logic [mstl_pkg::WORD_W-1:0]   size_mem [mstl_pkg::MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (wr.run_we) run_mem[wr.index[mstl_pkg::RUN_AW-1:0]] <= {wr.a, wr.b};
    if (wr.grp_we) begin
      grp_mem[wr.index[mstl_pkg::GRP_AW-1:0]]  <= {wr.a, wr.b};
      desc_mem[wr.index[mstl_pkg::GRP_AW-1:0]] <= wr.c;
    end
    if (wr.off_we)  off_mem[wr.index[mstl_pkg::CHK_AW-1:0]]  <= wr.a;
    if (wr.size_we) size_mem[wr.index[mstl_pkg::SMP_AW-1:0]] <= wr.a;
    rd.run  <= run_mem[run_addr];
    rd.grp  <= grp_mem[grp_addr];
    rd.desc <= desc_mem[grp_addr];
    rd.off  <= off_mem[off_addr];
    rd.size <= size_mem[size_addr];
  end

endmodule
`default_nettype wire

[tb/mstl_lookup_checker.sv]
// Checker for the media sample table lookup unit: mirrors the tables and
// registers, predicts each query result and compares it with the result beats.
// Depends on mstl_pkg.
module mstl_lookup_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mstl_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [mstl_pkg::WORD_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mstl_pkg::OP_W-1:0]     opcode,
  input  logic [mstl_pkg::ENTRY_W-1:0]  entry_index,
  input  logic [mstl_pkg::WORD_W-1:0]   word_a,
  input  logic [mstl_pkg::WORD_W-1:0]   word_b,
  input  logic [mstl_pkg::WORD_W-1:0]   word_c,
  input  logic [mstl_pkg::TIME_W-1:0]   query_time,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          found,
  input  logic [mstl_pkg::WORD_W-1:0]   sample_time,
  input  logic [mstl_pkg::WORD_W-1:0]   sample_duration,
  input  logic [mstl_pkg::WORD_W-1:0]   samples_in_result,
  input  logic [mstl_pkg::WORD_W-1:0]   byte_offset,
  input  logic [mstl_pkg::WORD_W-1:0]   byte_size,
  input  logic [mstl_pkg::WORD_W-1:0]   description_id,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mstl_pkg::*;

  typedef struct packed {
    logic        found;
    logic [31:0] time_start;
    logic [31:0] duration;
    logic [31:0] count;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] desc;
  } lookup_t;

  logic [63:0] run_tab  [TIME_RUNS];
  logic [63:0] grp_tab  [CHUNK_GROUPS];
  logic [31:0] desc_tab [CHUNK_GROUPS];
  logic [31:0] off_tab  [MAX_CHUNKS];
  logic [31:0] size_tab [MAX_SAMPLES];

  logic        m_chunk_mode;
  logic [31:0] m_uniform;
  logic [10:0] m_runs;
  logic [8:0]  m_groups;
  logic [12:0] m_total;

  lookup_t lookup_q[$];

  function automatic logic [63:0] clamp_count(logic [63:0] n, logic [63:0] depth);
    if (n == 0) return 1;
    return (n > depth) ? depth : n;
  endfunction

  function automatic lookup_t locate_sample(logic [TIME_W-1:0] qt);
    lookup_t     r;
    logic [63:0] t, runs, groups, total, cur_time, cur_smp, cnt, span, dur, k;
    logic [63:0] aligned, smp, gs, n, f0, f1, spc, first_chunk, chunk, fic, i, g;
    logic [31:0] off;
    r = '0;
    t = 64'(qt);
    runs   = clamp_count(64'(m_runs), TIME_RUNS);
    groups = clamp_count(64'(m_groups), CHUNK_GROUPS);
    total  = (m_total > MAX_SAMPLES) ? MAX_SAMPLES : 64'(m_total);
    cur_time = 0;
    cur_smp  = 0;
    // last run in use catches every later time
    for (i = 0; i + 1 < runs; i++) begin
      cnt  = {32'b0, run_tab[i][63:32]};
      span = cnt * {32'b0, run_tab[i][31:0]};
      if (t < cur_time + span) break;
      cur_time += span;
      cur_smp  += cnt;
    end
    dur = {32'b0, run_tab[i][31:0]};
    if (dur == 0) return r;
    k       = (t - cur_time) / dur;
    aligned = cur_time + k * dur;
    smp     = cur_smp + k;
    if (smp >= total) return r;
    gs = 0;
    for (g = 0; g < groups; g++) begin
      if (g + 1 == groups) begin
        n = total - gs;
      end else begin
        f0 = {32'b0, grp_tab[g][63:32]};
        f1 = {32'b0, grp_tab[g+1][63:32]};
        n  = (f1 > f0) ? (f1 - f0) * {32'b0, grp_tab[g][31:0]} : 0;
      end
      if (smp < gs + n) break;
      gs += n;
    end
    if (g >= groups) g = groups - 1;
    spc         = {32'b0, grp_tab[g][31:0]};
    first_chunk = {32'b0, grp_tab[g][63:32]};
    if (spc == 0) return r;
    k     = (smp - gs) / spc;
    fic   = gs + k * spc;
    chunk = k + first_chunk;
    if (chunk == 0 || chunk > MAX_CHUNKS) return r;
    off = off_tab[chunk - 1];
    r.found      = 1'b1;
    r.time_start = aligned[31:0];
    r.desc       = desc_tab[g];
    if (m_chunk_mode) begin
      r.duration = 32'(dur * spc);
      r.count    = spc[31:0];
      r.offset   = off;
      r.size     = 32'(spc * {32'b0, m_uniform});
    end else begin
      for (i = fic; i < smp; i++) off += size_tab[i];
      r.duration = dur[31:0];
      r.count    = 1;
      r.offset   = off;
      r.size     = size_tab[smp];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t got, want;
    int      bad;
    bad = 0;
    if (rst) begin
      m_chunk_mode <= 1'b0;
      m_uniform    <= '0;
      m_runs       <= 11'd1;
      m_groups     <= 9'd1;
      m_total      <= '0;
      lookup_q.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // results first, so a query taken on this edge cannot pair with it
      if (out_valid && !out_stall) begin
        got = '{found, sample_time, sample_duration, samples_in_result,
                byte_offset, byte_size, description_id};
        if (lookup_q.size() == 0) begin
          bad = 1;
          if (mismatches < 10)
            $display("%0t: unexpected result beat %p", $realtime, got);
        end else begin
          want = lookup_q.pop_front();
          if (got !== want) begin
            bad = 1;
            if (mismatches < 10)
              $display("%0t: result differs\n  exp %p\n  got %p", $realtime, want, got);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_CHUNK_MODE:   m_chunk_mode <= cfg_data[0];
          CFG_UNIFORM_SIZE: m_uniform    <= cfg_data;
          CFG_RUN_COUNT:    m_runs       <= cfg_data[10:0];
          CFG_GROUP_COUNT:  m_groups     <= cfg_data[8:0];
          CFG_TOTAL:        m_total      <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (opcode)
          OP_LOAD_RUN:
            if (entry_index < TIME_RUNS) run_tab[entry_index] = {word_a, word_b};
          OP_LOAD_GROUP:
            if (entry_index < CHUNK_GROUPS) begin
              grp_tab[entry_index]  = {word_a, word_b};
              desc_tab[entry_index] = word_c;
            end
          OP_LOAD_OFF:
            if (entry_index < MAX_CHUNKS) off_tab[entry_index] = word_a;
          OP_LOAD_SIZE:
            if (entry_index < MAX_SAMPLES) size_tab[entry_index] = word_a;
          OP_QUERY:
            lookup_q.push_back(locate_sample(query_time));
          default: ;
        endcase
      end
      mismatches  <= mismatches + bad;
      outstanding <= lookup_q.size();
    end
  end

endmodule

[tb/tb_media_sample_table_lookup_unit.sv]
// Testbench top for media_sample_table_lookup_unit: stimulus, idling and verdict.
// Depends on mstl_pkg, the block's RTL and mstl_lookup_checker.
module tb_media_sample_table_lookup_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mstl_pkg::*;

  // cycles with no beat at all before the run is abandoned; a query with
  // every walk at its longest stays well below this
  localparam int WATCHDOG_LIMIT = 200000;

  // leading part of the offset and size stores loaded at start; settings
  // keep first chunk numbers and total samples small enough that every
  // chunk and sample a query can reach lies inside it
  localparam int FILL_DEPTH = 256;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CFG_IW-1:0]   cfg_index;
  logic [WORD_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     opcode;
  logic [ENTRY_W-1:0]  entry_index;
  logic [WORD_W-1:0]   word_a, word_b, word_c;
  logic [TIME_W-1:0]   query_time;
  logic                out_valid;
  logic                out_stall;
  logic                found;
  logic [WORD_W-1:0]   sample_time, sample_duration, samples_in_result;
  logic [WORD_W-1:0]   byte_offset, byte_size, description_id;
  int                  mismatches;
  int                  outstanding;
  int                  idle_cycles;

  // idling knobs, percent per cycle
  int gap_pct;
  int stall_pct;

  // effective sizes of the current setting, used to aim the stimulus
  int n_runs, n_groups, n_total, time_span;

  media_sample_table_lookup_unit u_top (.*);

  mstl_lookup_checker u_check (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver stalls at random, independent of out_valid
  always @(posedge clk)
    out_stall <= ($urandom_range(0, 99) < stall_pct);

  // watchdog: counts cycles with no beat taken on either channel
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("media_sample_table_lookup_unit: mismatch");
      $finish;
    end
  end

  // one input beat; a random gap first, then hold until taken
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] idx,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [TIME_W-1:0] t);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < gap_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    word_a      <= a;
    word_b      <= b;
    word_c      <= c;
    query_time  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // drain: wait for every result, then let the block settle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  // all five registers, back to back; only called once the block is idle
  task automatic write_regs(input logic cm, input logic [31:0] uni,
                            input logic [10:0] rc, input logic [8:0] gc,
                            input logic [12:0] ts);
    cfg_write <= 1'b1;
    cfg_index <= CFG_CHUNK_MODE;   cfg_data <= {31'b0, cm}; @(posedge clk);
    cfg_index <= CFG_UNIFORM_SIZE; cfg_data <= uni;         @(posedge clk);
    cfg_index <= CFG_RUN_COUNT;    cfg_data <= 32'(rc);     @(posedge clk);
    cfg_index <= CFG_GROUP_COUNT;  cfg_data <= 32'(gc);     @(posedge clk);
    cfg_index <= CFG_TOTAL;        cfg_data <= 32'(ts);     @(posedge clk);
    cfg_write <= 1'b0;
    // counts of zero act as one, oversize counts as the store depth
    n_runs    = (rc == 0) ? 1 : (rc > TIME_RUNS) ? TIME_RUNS : rc;
    n_groups  = (gc == 0) ? 1 : (gc > CHUNK_GROUPS) ? CHUNK_GROUPS : gc;
    n_total   = (ts > MAX_SAMPLES) ? MAX_SAMPLES : ts;
    time_span = n_runs * 180 + 400;
  endtask

  // time run: mostly short runs, now and then an empty run, a zero
  // duration (not found) or a huge field
  task automatic load_run(input int idx);
    logic [31:0] cnt, dur;
    int          r;
    r   = $urandom_range(0, 99);
    cnt = (r < 4) ? 0 : (r < 7) ? $urandom : $urandom_range(1, 8);
    r   = $urandom_range(0, 99);
    dur = (r < 4) ? 0 : (r < 7) ? $urandom : $urandom_range(1, 40);
    send_beat(OP_LOAD_RUN, idx[ENTRY_W-1:0], cnt, dur, $urandom, TIME_W'($urandom));
  endtask

  // chunk group: ascending first chunks, with descending or zero chunk
  // numbers and zero samples per chunk mixed in
  task automatic load_group(input int idx);
    logic [31:0] first_chunk, spc;
    int          r;
    r           = $urandom_range(0, 99);
    first_chunk = (r < 5) ? $urandom_range(0, 8) : 32'(1 + 4 * idx);
    r           = $urandom_range(0, 99);
    spc         = (r < 4) ? 0 : $urandom_range(1, 6);
    send_beat(OP_LOAD_GROUP, idx[ENTRY_W-1:0], first_chunk, spc, $urandom,
              TIME_W'($urandom));
  endtask

  task automatic query(input logic [TIME_W-1:0] t);
    send_beat(OP_QUERY, ENTRY_W'($urandom), $urandom, $urandom, $urandom, t);
  endtask

  // random mix: mostly queries over the loaded span, rewrites of entries in
  // use, and some noise (any opcode and data, indexes past the entries in use)
  task automatic random_items(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        query(($urandom_range(0, 9) == 0) ? TIME_W'($urandom) :
              TIME_W'($urandom_range(0, time_span)));
      else if (r < 70)
        load_run($urandom_range(0, n_runs - 1));
      else if (r < 80)
        load_group($urandom_range(0, n_groups - 1));
      else if (r < 86)
        send_beat(OP_LOAD_OFF, ENTRY_W'($urandom_range(0, 63)), $urandom, $urandom,
                  $urandom, TIME_W'($urandom));
      else if (r < 92 && n_total > 0)
        send_beat(OP_LOAD_SIZE, ENTRY_W'($urandom_range(0, n_total - 1)),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000),
                  $urandom, $urandom, TIME_W'($urandom));
      else
        send_beat(OP_W'($urandom_range(0, 7)),
                  ENTRY_W'($urandom_range(CHUNK_GROUPS, 4095)), $urandom, $urandom,
                  $urandom, TIME_W'($urandom));
    end
  endtask

  initial begin
    logic        cm;
    logic [31:0] uni;
    logic [10:0] rc;
    logic [8:0]  gc;
    logic [12:0] ts;
    int          count;

    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = CFG_CHUNK_MODE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    opcode      = OP_QUERY;
    entry_index = '0;
    word_a      = '0;
    word_b      = '0;
    word_c      = '0;
    query_time  = '0;
    out_stall   = 1'b0;
    idle_cycles = 0;
    gap_pct     = 0;
    stall_pct   = 0;
    n_runs      = 1;
    n_groups    = 1;
    n_total     = 0;
    time_span   = 400;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // entries the reset setting can reach, and the leading part of the
    // offset and size stores
    load_run(0);
    load_group(0);
    for (int i = 0; i < FILL_DEPTH; i++)
      send_beat(OP_LOAD_OFF, ENTRY_W'(i), $urandom, $urandom, $urandom,
                TIME_W'($urandom));
    for (int i = 0; i < FILL_DEPTH; i++)
      send_beat(OP_LOAD_SIZE, ENTRY_W'(i), $urandom, $urandom, $urandom,
                TIME_W'($urandom));

    // directed: reset setting has no samples, so every query misses
    query('0);
    query('1);
    // unknown opcodes and indexes past the smaller stores are dropped
    send_beat(3'd5, '1, '1, '1, '1, '1);
    send_beat(3'd6, '0, '0, '0, '0, '0);
    send_beat(3'd7, 12'd100, $urandom, $urandom, $urandom, TIME_W'($urandom));
    send_beat(OP_LOAD_RUN, '1, 32'd1, 32'd1, '1, '1);
    send_beat(OP_LOAD_GROUP, '1, 32'd0, 32'd0, '1, '1);
    send_beat(OP_LOAD_RUN, 12'd0, 32'd5, 32'd10, '0, '0);
    send_beat(OP_LOAD_GROUP, 12'd0, 32'd1, 32'd3, 32'hFFFF_FFFF, '0);
    send_beat(OP_LOAD_OFF, '1, '1, '0, '0, '0);
    send_beat(OP_LOAD_SIZE, '1, '1, '0, '0, '0);
    // chunk holding the last sample of the largest track
    send_beat(OP_LOAD_OFF, 12'd1365, $urandom, '0, '0, '0);
    settle();
    // single run catches every time; largest sample count
    write_regs(1'b0, 32'd0, 11'd1, 9'd1, 13'd4096);
    query('0);
    query(31'd9);
    query(31'd10);
    query(31'd40959);
    query(31'd40960);
    query('1);
    settle();
    // oversize sample count acts as the largest
    write_regs(1'b1, '1, 11'd1, 9'd1, 13'd8191);
    query('0);
    query(31'd35);
    query('1);
    settle();

    // phases: each a register setting, fresh tables in use and random
    // items, cycling through the four idling patterns
    for (int p = 0; p < 12; p++) begin
      settle();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 77; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 77; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      count = 90;
      case (p)
        0: begin cm = 0; uni = 0;  rc = 1; gc = 1; ts = 64;  end
        1: begin cm = 1; uni = '1; rc = 4; gc = 3; ts = 200; end
        2: begin cm = 0; uni = $urandom; rc = 0; gc = 0; ts = 100; end
        3: begin cm = 1; uni = 1;  rc = 8;  gc = 6; ts = 220; end
        4: begin cm = 0; uni = 0;  rc = 16; gc = 8; ts = 120; end
        // more runs and groups: longer walks
        5: begin cm = 1; uni = $urandom; rc = 64; gc = 32; ts = 128; end
        6: begin cm = 0; uni = '1; rc = 48; gc = 24; ts = 128; end
        default: begin
          cm  = $urandom_range(0, 1);
          uni = $urandom;
          rc  = $urandom_range(1, 12);
          gc  = $urandom_range(1, 8);
          ts  = $urandom_range(1, 128);
        end
      endcase
      write_regs(cm, uni, rc, gc, ts);
      for (int i = 0; i < n_runs; i++) load_run(i);
      for (int i = 0; i < n_groups; i++) load_group(i);
      random_items(count);
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("media_sample_table_lookup_unit: match");
    else
      $display("media_sample_table_lookup_unit: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/core/mstl_pkg.sv
rtl/core/mstl_arith.sv
rtl/core/mstl_tables.sv
rtl/core/media_sample_table_lookup_unit.sv
tb/mstl_lookup_checker.sv
tb/tb_media_sample_table_lookup_unit.sv
